// ===== hdl/lobm_pkg.sv =====
// Shared types and constants for the limit order book matcher.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;

  // Book geometry
  localparam int ORDERS_PER_SIDE = 32;
  localparam int IW = (ORDERS_PER_SIDE > 1) ? $clog2(ORDERS_PER_SIDE) : 1;
  localparam int CW = $clog2(ORDERS_PER_SIDE + 1);
  localparam int MEM_DEPTH = 2 * (1 << IW);

  // Field widths
  localparam int PW = 32;
  localparam int QW = 32;
  localparam int DW = 32;
  localparam int TW = 48;

  // Book sides
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_TRADE   = 3'd0;
  localparam logic [2:0] KIND_RESTED  = 3'd1;
  localparam logic [2:0] KIND_FILLED  = 3'd2;
  localparam logic [2:0] KIND_MKT_DROP = 3'd3;
  localparam logic [2:0] KIND_FULL    = 3'd4;

  typedef struct packed {
    logic [DW-1:0] order_id;
    logic          is_sell;
    logic          is_market;
    logic [PW-1:0] limit_price;
    logic [QW-1:0] order_quantity;
    logic [TW-1:0] order_time;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]    item_kind;
    logic [DW-1:0] buyer_id;
    logic [DW-1:0] seller_id;
    logic [PW-1:0] trade_price;
    logic [QW-1:0] trade_quantity;
    logic [TW-1:0] trade_time;
    logic          last;
  } out_beat_t;

  // One resting order
  typedef struct packed {
    logic [PW-1:0] price;
    logic [QW-1:0] qty;
    logic [DW-1:0] id;
    logic [TW-1:0] tm;
  } entry_t;

  // Sequencer to book storage
  typedef struct packed {
    logic          rd_en;
    logic          rd_side;
    logic [IW-1:0] rd_idx;
    logic          wr_en;
    logic          wr_side;
    logic [IW-1:0] wr_idx;
    logic          pop;
    logic          grow;
    logic          side;   // side for pop / grow
  } book_cmd_t;

  // Shared compare unit results
  typedef struct packed {
    logic [QW-1:0] fill;
    logic [QW-1:0] new_qty;
    logic [QW-1:0] new_rem;
    logic [TW-1:0] when;
    logic          cross_ok;
    logic          scan_go;
  } unit_res_t;

  // Logical position behind the head, wrapped into the ring
  function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] head,
                                              input logic [IW-1:0] idx);
    logic [IW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (IW+1)'(ORDERS_PER_SIDE)) begin
      sum = sum - (IW+1)'(ORDERS_PER_SIDE);
    end
    return sum[IW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/limit_order_book_matcher_core.sv =====
// Channel  | dir | beat type             | handshake
// in_      | in  | lobm_pkg::in_beat_t   | in_valid / in_ready
// out_     | out | lobm_pkg::out_beat_t  | out_valid / out_ready
//
// One order at a time. Each trade is a book read, then a fill; closing is
// a last check, a decision and a status beat. A resting remainder first
// reads and compares each entry that stays ahead of it, then moves the
// entries behind its place back one each, a read and a write apiece, and
// is then written in. All of it is paced by the book accesses, which the
// sequencer issues one at a time.
// Reset empties both sides at once. Output stalls hold the sequencer in
// place where it has a beat to send; a finished beat waits in the output
// register. Depends on lobm_pkg, lobm_book and lobm_unit.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book_matcher_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lobm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lobm_pkg::out_beat_t out_data
);
  import lobm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MRD  = 4'd1;
  localparam logic [3:0] S_MEV  = 4'd2;
  localparam logic [3:0] S_FIN  = 4'd3;
  localparam logic [3:0] S_SRD  = 4'd4;
  localparam logic [3:0] S_SEV  = 4'd5;
  localparam logic [3:0] S_HRD  = 4'd6;
  localparam logic [3:0] S_HWR  = 4'd7;
  localparam logic [3:0] S_INS  = 4'd8;
  localparam logic [3:0] S_STAT = 4'd9;

  logic [3:0]    state_r, state_nxt;
  in_beat_t      tk_r, tk_nxt;
  logic [QW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [2:0]    kind_r, kind_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_data_r, out_data_nxt;

  book_cmd_t     cmd;
  entry_t        wr_data;
  entry_t        rd_data;
  logic [CW-1:0] bid_cnt, ask_cnt;
  logic [CW-1:0] opp_cnt, own_cnt;
  logic          opp_side, own_side;
  logic          slot_free;
  unit_res_t     res;

  lobm_book u_book (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .bid_cnt (bid_cnt),
    .ask_cnt (ask_cnt)
  );

  lobm_unit u_unit (
    .rem         (rem_r),
    .limit_price (tk_r.limit_price),
    .taker_time  (tk_r.order_time),
    .is_sell     (tk_r.is_sell),
    .maker       (rd_data),
    .res         (res)
  );

  // A sell takes from the bids and rests on the asks
  assign opp_side  = tk_r.is_sell ? SIDE_BID : SIDE_ASK;
  assign own_side  = tk_r.is_sell ? SIDE_ASK : SIDE_BID;
  assign opp_cnt   = tk_r.is_sell ? bid_cnt : ask_cnt;
  assign own_cnt   = tk_r.is_sell ? ask_cnt : bid_cnt;
  assign slot_free = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    tk_nxt        = tk_r;
    rem_nxt       = rem_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    pos_nxt       = pos_r;
    kind_nxt      = kind_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    wr_data       = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tk_nxt    = in_data;
          rem_nxt   = in_data.order_quantity;
          k_nxt     = '0;
          state_nxt = S_MRD;
        end
      end
      S_MRD: begin
        if (rem_r == '0 || opp_cnt == '0 || k_r == CW'(ORDERS_PER_SIDE)) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_side = opp_side;
          cmd.rd_idx  = '0;
          state_nxt   = S_MEV;
        end
      end
      S_MEV: begin
        if (!tk_r.is_market && !res.cross_ok) begin
          state_nxt = S_FIN;
        end else if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.item_kind    = KIND_TRADE;
          out_data_nxt.buyer_id     = tk_r.is_sell ? rd_data.id : tk_r.order_id;
          out_data_nxt.seller_id    = tk_r.is_sell ? tk_r.order_id : rd_data.id;
          out_data_nxt.trade_price  = rd_data.price;
          out_data_nxt.trade_quantity = res.fill;
          out_data_nxt.trade_time   = res.when;
          out_data_nxt.last         = 1'b0;
          rem_nxt = res.new_rem;
          k_nxt   = k_r + CW'(1);
          cmd.side = opp_side;
          if (res.new_qty == '0) begin
            cmd.pop = 1'b1;
          end else begin
            cmd.wr_en   = 1'b1;
            cmd.wr_side = opp_side;
            cmd.wr_idx  = '0;
            wr_data.qty = res.new_qty;
          end
          state_nxt = S_MRD;
        end
      end
      S_FIN: begin
        priority if (rem_r == '0) begin
          kind_nxt  = KIND_FILLED;
          state_nxt = S_STAT;
        end else if (tk_r.is_market) begin
          kind_nxt  = KIND_MKT_DROP;
          state_nxt = S_STAT;
        end else if (own_cnt >= CW'(ORDERS_PER_SIDE)) begin
          kind_nxt  = KIND_FULL;
          state_nxt = S_STAT;
        end else begin
          i_nxt     = '0;
          state_nxt = S_SRD;
        end
      end
      // Find the first entry that the new order goes ahead of
      S_SRD: begin
        if (i_r == own_cnt) begin
          pos_nxt   = i_r;
          i_nxt     = own_cnt;
          state_nxt = S_HRD;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_side = own_side;
          cmd.rd_idx  = i_r[IW-1:0];
          state_nxt   = S_SEV;
        end
      end
      S_SEV: begin
        if (res.scan_go) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SRD;
        end else begin
          pos_nxt   = i_r;
          i_nxt     = own_cnt;
          state_nxt = S_HRD;
        end
      end
      // Move entries back one place, tail first
      S_HRD: begin
        if (i_r == pos_r) begin
          state_nxt = S_INS;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_side = own_side;
          cmd.rd_idx  = IW'(i_r - CW'(1));
          state_nxt   = S_HWR;
        end
      end
      S_HWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_side = own_side;
        cmd.wr_idx  = i_r[IW-1:0];
        i_nxt       = i_r - CW'(1);
        state_nxt   = S_HRD;
      end
      S_INS: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_side   = own_side;
        cmd.wr_idx    = pos_r[IW-1:0];
        cmd.grow      = 1'b1;
        cmd.side      = own_side;
        wr_data.price = tk_r.limit_price;
        wr_data.qty   = rem_r;
        wr_data.id    = tk_r.order_id;
        wr_data.tm    = tk_r.order_time;
        kind_nxt      = KIND_RESTED;
        state_nxt     = S_STAT;
      end
      S_STAT: begin
        if (slot_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.item_kind      = kind_r;
          out_data_nxt.buyer_id       = tk_r.order_id;
          out_data_nxt.seller_id      = tk_r.order_id;
          out_data_nxt.trade_price    = '0;
          out_data_nxt.trade_quantity = rem_r;
          out_data_nxt.trade_time     = tk_r.order_time;
          out_data_nxt.last           = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    tk_r       <= tk_nxt;
    rem_r      <= rem_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    pos_r      <= pos_nxt;
    kind_r     <= kind_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== hdl/lobm_book.sv =====
// Book storage: one memory for both sides kept as rings, plus head pointers
// and fill counts. Depends on lobm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lobm_book (
  input  logic               clk,
  input  logic               rst_n,
  input  lobm_pkg::book_cmd_t cmd,
  input  lobm_pkg::entry_t   wr_data,
  output lobm_pkg::entry_t   rd_data,
  output logic [lobm_pkg::CW-1:0] bid_cnt,
  output logic [lobm_pkg::CW-1:0] ask_cnt
);
  import lobm_pkg::*;

  entry_t        mem [MEM_DEPTH];
  entry_t        rd_data_r;
  logic [IW-1:0] head_r [2];
  logic [IW-1:0] head_nxt [2];
  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] cnt_nxt [2];
  logic [IW:0]   rd_addr;
  logic [IW:0]   wr_addr;

  // Physical addresses: side selects the half, ring slot inside it
  assign rd_addr = {cmd.rd_side, ring_slot(head_r[cmd.rd_side], cmd.rd_idx)};
  assign wr_addr = {cmd.wr_side, ring_slot(head_r[cmd.wr_side], cmd.wr_idx)};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

  // Pop advances the head, grow adds one at the tail
  always_comb begin
    head_nxt[0] = head_r[0];
    head_nxt[1] = head_r[1];
    cnt_nxt[0]  = cnt_r[0];
    cnt_nxt[1]  = cnt_r[1];
    if (cmd.pop) begin
      head_nxt[cmd.side] = ring_slot(head_r[cmd.side], IW'(1));
      cnt_nxt[cmd.side]  = cnt_r[cmd.side] - CW'(1);
    end else if (cmd.grow) begin
      cnt_nxt[cmd.side]  = cnt_r[cmd.side] + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r[0] <= '0;
      head_r[1] <= '0;
      cnt_r[0]  <= '0;
      cnt_r[1]  <= '0;
    end else begin
      head_r[0] <= head_nxt[0];
      head_r[1] <= head_nxt[1];
      cnt_r[0]  <= cnt_nxt[0];
      cnt_r[1]  <= cnt_nxt[1];
    end
  end

  assign bid_cnt = cnt_r[SIDE_BID];
  assign ask_cnt = cnt_r[SIDE_ASK];

endmodule
`default_nettype wire

// ===== hdl/lobm_unit.sv =====
// Shared compare unit: fill size, timestamps and price checks against the
// entry just read from the book. Depends on lobm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lobm_unit (
  input  logic [lobm_pkg::QW-1:0] rem,
  input  logic [lobm_pkg::PW-1:0] limit_price,
  input  logic [lobm_pkg::TW-1:0] taker_time,
  input  logic                    is_sell,
  input  lobm_pkg::entry_t        maker,
  output lobm_pkg::unit_res_t     res
);
  import lobm_pkg::*;

  always_comb begin
    res.fill    = (rem < maker.qty) ? rem : maker.qty;
    res.new_qty = maker.qty - res.fill;
    res.new_rem = rem - res.fill;
    res.when    = (taker_time > maker.tm) ? taker_time : maker.tm;
    // taker may trade at the maker price
    res.cross_ok = is_sell ? (limit_price <= maker.price)
                           : (limit_price >= maker.price);
    // resting entry stays ahead of the new order
    res.scan_go  = is_sell ? (maker.price <= limit_price)
                           : (maker.price >= limit_price);
  end

endmodule
`default_nettype wire

// ===== hdl/lobm_checker.sv =====
// Port-level checks for the matcher core, attached by bind.
// Depends on lobm_pkg and limit_order_book_matcher_core.
`timescale 1ns / 1ps
`default_nettype none
module lobm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lobm_pkg::out_beat_t out_data
);
  import lobm_pkg::*;

  // An accepted order makes the block busy; in_ready does not stay high after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Trades never close an order
  a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_TRADE |-> !out_data.last)
    else $error("trade beat marked last");

  // Trades move a nonzero quantity
  a_trade_qty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_TRADE |-> out_data.trade_quantity != '0)
    else $error("zero quantity trade");

endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
